// ===== sv/mfsm_pkg.sv =====
// mfsm_pkg: widths, defaults and filter constants for the modem frame sample monitor.
// Has no dependencies; imported by modem_frame_sample_monitor_top.
`default_nettype none
package mfsm_pkg;

    localparam int WINDOW_LEN_DEF  = 20;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int MEAS_W = 24;
    localparam int CNT_W  = 32;
    localparam int STAT_W = 16;
    localparam int SRC_W  = 2;
    localparam int NUM_STATUS = 4;

    // filter: new = old*30/100 + sample*70/100
    localparam int MUL_OLD = 30;
    localparam int MUL_NEW = 70;

    // x/100 == (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2**31
    localparam int          DIV_SHIFT = 38;
    localparam logic [31:0] DIV_RECIP = 32'd2748779070;

endpackage
`default_nettype wire

// ===== sv/modem_frame_sample_monitor_top.sv =====
// modem_frame_sample_monitor_top: frame counters, 30/70 smoothing filter, window peak-to-peak.
// Depends on mfsm_pkg. Window samples live in a one-port-write, one-port-read synchronous RAM.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------------
//   in      | in        | in_valid / in_ready | func, frame_failed, is_status, measurement,
//           |           |                     | status_source, status_payload
//   out     | out       | out_valid/out_ready | counters, filter, latest, span, status words
//
// Sample frame: after accept, S_MUL forms the 30/70 products, then S_DIV_OLD and S_DIV_NEW run the
// filter divide by 100 through one reciprocal multiplier, then S_SCAN makes one RAM read per window entry.
// Other frames and the clear command go straight to S_EMIT, with no RAM write.
// Reset empties the window through per-entry valid bits; no clearing pass.
// A result waits in the output register while the next beat is taken; a stalled output
// holds the block only when the next result is ready to load.
`default_nettype none
module modem_frame_sample_monitor_top #(
    parameter int WINDOW_LEN  = mfsm_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = mfsm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          func,
    input  wire logic                          frame_failed,
    input  wire logic                          is_status,
    input  wire logic [mfsm_pkg::MEAS_W-1:0]   measurement,
    input  wire logic [mfsm_pkg::SRC_W-1:0]    status_source,
    input  wire logic [mfsm_pkg::STAT_W-1:0]   status_payload,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [mfsm_pkg::CNT_W-1:0]         total_frames,
    output logic [mfsm_pkg::CNT_W-1:0]         bad_frames,
    output logic [mfsm_pkg::CNT_W-1:0]         sample_frames,
    output logic [mfsm_pkg::CNT_W-1:0]         status_frames,
    output logic [mfsm_pkg::MEAS_W-1:0]        smoothed_sample,
    output logic [mfsm_pkg::MEAS_W-1:0]        latest_sample,
    output logic [mfsm_pkg::MEAS_W-1:0]        peak_to_peak,
    output logic [mfsm_pkg::STAT_W-1:0]        status_word_a,
    output logic [mfsm_pkg::STAT_W-1:0]        status_word_b,
    output logic [mfsm_pkg::STAT_W-1:0]        status_word_c,
    output logic [mfsm_pkg::STAT_W-1:0]        status_word_d
);
    import mfsm_pkg::*;

    localparam int SW     = (SAMPLE_BITS < MEAS_W) ? SAMPLE_BITS : MEAS_W;
    localparam int PW     = SW + 7;
    localparam int QW     = SW + 1;
    localparam int PROD_W = PW + 32;
    localparam int AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_LEN - 1);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_MUL      = 6'b000010,
        S_DIV_OLD  = 6'b000100,
        S_DIV_NEW  = 6'b001000,
        S_SCAN     = 6'b010000,
        S_EMIT     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  total_reg, bad_reg, sample_reg, status_cnt_reg;
    logic [SW-1:0]     filter_reg, last_reg, span_reg;
    logic [STAT_W-1:0] words_reg [NUM_STATUS];
    logic [AW-1:0]     wp_reg;
    logic [WINDOW_LEN-1:0] entry_valid_reg;

    logic [PW-1:0]     p_old_reg, p_new_reg;
    logic [QW-1:0]     q_old_reg;

    logic [AW-1:0]     scan_idx_reg;
    logic              scan_done_reg;
    logic              rd_first_reg, rd_live_reg, rd_last_reg, rd_entry_valid_reg;
    logic [SW-1:0]     rd_data_reg;
    logic [SW-1:0]     hi_reg, lo_reg;

    logic [SW-1:0]     window_mem [WINDOW_LEN];

    logic              out_valid_reg;
    logic [CNT_W-1:0]  o_total_reg, o_bad_reg, o_sample_reg, o_status_reg;
    logic [SW-1:0]     o_filter_reg, o_last_reg, o_span_reg;
    logic [STAT_W-1:0] o_words_reg [NUM_STATUS];

    logic              in_fire, sample_fire, mem_we, emit_load;
    logic [SW-1:0]     meas_s, rd_value, hi_upd, lo_upd;
    logic [PW-1:0]     div_in;
    logic [PROD_W-1:0] div_prod;
    logic [QW-1:0]     div_q;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign meas_s      = measurement[SW-1:0];
    assign sample_fire = in_fire && !func && !frame_failed && !is_status;
    assign mem_we      = sample_fire;
    assign emit_load   = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    assign div_in   = (state_reg == S_DIV_OLD) ? p_old_reg : p_new_reg;
    assign div_prod = PROD_W'(div_in) * PROD_W'(DIV_RECIP);
    assign div_q    = QW'(div_prod >> DIV_SHIFT);

    assign rd_value = rd_entry_valid_reg ? rd_data_reg : '0;
    assign hi_upd   = (rd_first_reg || rd_value > hi_reg) ? rd_value : hi_reg;
    assign lo_upd   = (rd_first_reg || rd_value < lo_reg) ? rd_value : lo_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_fire) state_next = sample_fire ? S_MUL : S_EMIT;
            S_MUL:     state_next = S_DIV_OLD;
            S_DIV_OLD: state_next = S_DIV_NEW;
            S_DIV_NEW: state_next = S_SCAN;
            S_SCAN:    if (rd_last_reg) state_next = S_EMIT;
            S_EMIT:    if (emit_load) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // window RAM: write at accept, registered read during scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[wp_reg] <= meas_s;
        end
        rd_data_reg <= window_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            total_reg       <= '0;
            bad_reg         <= '0;
            sample_reg      <= '0;
            status_cnt_reg  <= '0;
            filter_reg      <= '0;
            last_reg        <= '0;
            span_reg        <= '0;
            for (int i = 0; i < NUM_STATUS; i++)
            begin
                words_reg[i] <= '0;
            end
            wp_reg          <= '0;
            entry_valid_reg <= '0;
            scan_idx_reg    <= '0;
            scan_done_reg   <= 1'b0;
            rd_first_reg    <= 1'b0;
            rd_live_reg     <= 1'b0;
            rd_last_reg     <= 1'b0;
            rd_entry_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_fire)
            begin
                if (func)
                begin
                    bad_reg <= '0;
                end
                else
                begin
                    total_reg <= total_reg + 1'b1;
                    if (frame_failed)
                    begin
                        bad_reg <= bad_reg + 1'b1;
                        wp_reg  <= '0;
                    end
                    else if (!is_status)
                    begin
                        sample_reg <= sample_reg + 1'b1;
                        last_reg   <= meas_s;
                        entry_valid_reg[wp_reg] <= 1'b1;
                        wp_reg <= (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
                    end
                    else
                    begin
                        status_cnt_reg <= status_cnt_reg + 1'b1;
                        words_reg[status_source] <= status_payload;
                    end
                end
            end

            if (state_reg == S_DIV_NEW)
            begin
                filter_reg <= SW'(q_old_reg + div_q);
            end

            // scan: address in S_SCAN, read data in the next cycle
            if (state_reg == S_DIV_NEW)
            begin
                scan_idx_reg  <= '0;
                scan_done_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN && !scan_done_reg)
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    scan_done_reg <= 1'b1;
                end
                else
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            rd_live_reg        <= (state_reg == S_SCAN) && !scan_done_reg;
            rd_first_reg       <= (state_reg == S_SCAN) && !scan_done_reg && (scan_idx_reg == '0);
            rd_last_reg        <= (state_reg == S_SCAN) && !scan_done_reg
                                  && (scan_idx_reg == LAST_IDX);
            rd_entry_valid_reg <= entry_valid_reg[scan_idx_reg];

            if (rd_last_reg)
            begin
                span_reg <= hi_upd - lo_upd;
            end

            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            p_old_reg <= PW'(filter_reg) * PW'(MUL_OLD);
            p_new_reg <= PW'(last_reg) * PW'(MUL_NEW);
        end
        if (state_reg == S_DIV_OLD)
        begin
            q_old_reg <= div_q;
        end
        if (rd_live_reg)
        begin
            hi_reg <= hi_upd;
            lo_reg <= lo_upd;
        end
        if (emit_load)
        begin
            o_total_reg  <= total_reg;
            o_bad_reg    <= bad_reg;
            o_sample_reg <= sample_reg;
            o_status_reg <= status_cnt_reg;
            o_filter_reg <= filter_reg;
            o_last_reg   <= last_reg;
            o_span_reg   <= rd_last_reg ? (hi_upd - lo_upd) : span_reg;
            for (int i = 0; i < NUM_STATUS; i++)
            begin
                o_words_reg[i] <= words_reg[i];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign total_frames    = o_total_reg;
    assign bad_frames      = o_bad_reg;
    assign sample_frames   = o_sample_reg;
    assign status_frames   = o_status_reg;
    assign smoothed_sample = MEAS_W'(o_filter_reg);
    assign latest_sample   = MEAS_W'(o_last_reg);
    assign peak_to_peak    = MEAS_W'(o_span_reg);
    assign status_word_a   = o_words_reg[0];
    assign status_word_b   = o_words_reg[1];
    assign status_word_c   = o_words_reg[2];
    assign status_word_d   = o_words_reg[3];

    a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_IDX)
        else $error("window write position out of range");

    a_sample_to_filter: assert property (@(posedge clk) disable iff (!rst_n)
        sample_fire |=> (state_reg == S_MUL) && (last_reg == $past(meas_s)))
        else $error("sample beat did not start the filter");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        rd_last_reg |-> (hi_upd >= lo_upd))
        else $error("window maximum below minimum");

    a_emit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_last_reg |-> (state_reg == S_SCAN))
        else $error("scan finished outside scan state");

endmodule
`default_nettype wire
